// File: rtl/sitda_pkg.sv
package sitda_pkg;

    // Field widths of the input and result items.
    localparam int VALUE_W  = 32;
    localparam int WIDTH_W  = 5;
    localparam int CHAR_W   = 8;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 8;

    // Largest field width honored; wider requests saturate here.
    localparam int MAX_WIDTH = 16;

    // A 32-bit magnitude needs at most ten decimal digits.
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);

    // ASCII codes.
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_PREP,
        ST_SIGN,
        ST_PAD,
        ST_DIGIT
    } state_t;

    typedef enum logic [1:0] {
        SEL_SIGN,
        SEL_PAD,
        SEL_DIGIT
    } char_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;
        logic      shift;
        logic      prep;
        logic      pad_dec;
        logic      dig_dec;
        char_sel_t sel;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic conv_done;
        logic neg;
        logic pad_any;
        logic dig_zero;
    } status_t;

endpackage

// File: rtl/sitda_dp.sv
module sitda_dp (
    input  logic                            aclk,
    input  logic [sitda_pkg::VALUE_W-1:0]   value,
    input  logic [sitda_pkg::WIDTH_W-1:0]   min_width,
    input  logic [sitda_pkg::CHAR_W-1:0]    pad_char,
    input  sitda_pkg::cmd_t                 cmd,
    output sitda_pkg::status_t              status,
    output logic [sitda_pkg::CHAR_W-1:0]    out_char,
    output logic                            last
);
    import sitda_pkg::*;

    logic [VALUE_W-1:0]   mag_reg, mag_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic                 neg_reg, neg_next;
    logic [WIDTH_W-1:0]   width_reg, width_next;
    logic [CHAR_W-1:0]    pad_reg, pad_next;
    logic [WIDTH_W-1:0]   pad_cnt_reg, pad_cnt_next;
    logic [DIG_IDX_W-1:0] dig_idx_reg, dig_idx_next;

    logic [BCD_W-1:0]     bcd_adj;
    logic [DIG_IDX_W-1:0] top_idx;
    logic [WIDTH_W-1:0]   num_digits;
    logic [3:0]           cur_digit;

    // Add-3 correction on every BCD digit before each shift.
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_reg[4*d +: 4] >= 4'd5) begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end else begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
    end

    // Index of the most significant nonzero digit; zero shows as one digit.
    always_comb begin
        top_idx = '0;
        for (int d = 1; d < NUM_DIGITS; d++) begin
            if (bcd_reg[4*d +: 4] != 4'd0) begin
                top_idx = DIG_IDX_W'(d);
            end
        end
        num_digits = WIDTH_W'(top_idx) + WIDTH_W'(1);
    end

    // Register updates for loading, conversion and character stepping.
    always_comb begin
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        neg_next     = neg_reg;
        width_next   = width_reg;
        pad_next     = pad_reg;
        pad_cnt_next = pad_cnt_reg;
        dig_idx_next = dig_idx_reg;
        if (cmd.load) begin
            neg_next     = value[VALUE_W-1];
            mag_next     = value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
            bcd_next     = '0;
            bit_cnt_next = '0;
            pad_next     = pad_char;
            if (32'(min_width) > MAX_WIDTH) begin
                width_next = WIDTH_W'(MAX_WIDTH);
            end else begin
                width_next = min_width;
            end
        end
        if (cmd.shift) begin
            bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
            mag_next     = {mag_reg[VALUE_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
        end
        if (cmd.prep) begin
            dig_idx_next = top_idx;
            if (width_reg > num_digits) begin
                pad_cnt_next = width_reg - num_digits;
            end else begin
                pad_cnt_next = '0;
            end
        end
        if (cmd.pad_dec) begin
            pad_cnt_next = pad_cnt_reg - WIDTH_W'(1);
        end
        if (cmd.dig_dec) begin
            dig_idx_next = dig_idx_reg - DIG_IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        neg_reg     <= neg_next;
        width_reg   <= width_next;
        pad_reg     <= pad_next;
        pad_cnt_reg <= pad_cnt_next;
        dig_idx_reg <= dig_idx_next;
    end

    // Status back to the controller.
    always_comb begin
        status.conv_done = (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1));
        status.neg       = neg_reg;
        status.pad_any   = (pad_cnt_reg != '0);
        status.dig_zero  = (dig_idx_reg == '0);
    end

    // Character select for the result item.
    assign cur_digit = bcd_reg[4*dig_idx_reg +: 4];

    always_comb begin
        unique case (cmd.sel)
            SEL_SIGN:  out_char = CH_MINUS;
            SEL_PAD:   out_char = pad_reg;
            SEL_DIGIT: out_char = CH_ZERO + CHAR_W'(cur_digit);
            default:   out_char = pad_reg;
        endcase
        last = (cmd.sel == SEL_DIGIT) && status.dig_zero;
    end

endmodule

// File: rtl/sitda_ctrl.sv
module sitda_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  sitda_pkg::status_t  status,
    output sitda_pkg::cmd_t     cmd
);
    import sitda_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_CONVERT;
            end
            ST_CONVERT: begin
                if (status.conv_done) state_next = ST_PREP;
            end
            ST_PREP: begin
                state_next = status.neg ? ST_SIGN : ST_PAD;
            end
            ST_SIGN: begin
                if (m_tready) state_next = ST_PAD;
            end
            ST_PAD: begin
                if (!status.pad_any) state_next = ST_DIGIT;
            end
            ST_DIGIT: begin
                if (m_tready && status.dig_zero) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshakes and datapath commands.
    always_comb begin
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd.load    = 1'b0;
        cmd.shift   = 1'b0;
        cmd.prep    = 1'b0;
        cmd.pad_dec = 1'b0;
        cmd.dig_dec = 1'b0;
        cmd.sel     = SEL_PAD;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_CONVERT: begin
                cmd.shift = 1'b1;
            end
            ST_PREP: begin
                cmd.prep = 1'b1;
            end
            ST_SIGN: begin
                m_tvalid = 1'b1;
                cmd.sel  = SEL_SIGN;
            end
            ST_PAD: begin
                m_tvalid    = status.pad_any;
                cmd.pad_dec = status.pad_any && m_tready;
            end
            ST_DIGIT: begin
                m_tvalid    = 1'b1;
                cmd.sel     = SEL_DIGIT;
                cmd.dig_dec = m_tready && !status.dig_zero;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/signed_int_to_decimal_ascii.sv
// Sequence: the first character is valid after item acceptance, the 32 shift-and-add-3
// BCD steps and the setup state; a digit with no sign or pad before it also waits out the pad state.
// A new item is taken only after the last character of the current one has left; the pad
// state always passes once before the digits; characters leave one per cycle under m_tready.
// Reset: aresetn is synchronous, active low, and returns the controller to idle.
module signed_int_to_decimal_ascii (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] value, [36:32] min_width, [44:37] pad_char, [47:45] zero
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_char
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);
    import sitda_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencing of conversion and character output.
    sitda_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Magnitude, BCD digits, counters and character select.
    sitda_dp u_dp (
        .aclk      (aclk),
        .value     (s_tdata[31:0]),
        .min_width (s_tdata[36:32]),
        .pad_char  (s_tdata[44:37]),
        .cmd       (cmd),
        .status    (status),
        .out_char  (m_tdata),
        .last      (m_tlast)
    );

endmodule
